/* hdl/bfp_pkg.sv */
package bfp_pkg;

    // Default width of a flux interval in the result.
    localparam int INTERVAL_BITS_DEFAULT = 20;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    // Register widths.
    localparam int BITCELL_BITS = 14;
    localparam int CYL_BITS     = 8;
    localparam int SHIFT_BITS   = 8;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_BITCELL_TIME  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CYLINDER      = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRECOMP_START = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRECOMP_SHIFT = 4'd3;

    // Reset values of the registers.
    localparam logic [BITCELL_BITS-1:0] BITCELL_TIME_RESET  = 14'd2000;
    localparam logic [CYL_BITS-1:0]     CYLINDER_RESET      = 8'd0;
    localparam logic [CYL_BITS-1:0]     PRECOMP_START_RESET = 8'd40;
    localparam logic [SHIFT_BITS-1:0]   PRECOMP_SHIFT_RESET = 8'd240;

    typedef struct packed {
        logic [BITCELL_BITS-1:0] bitcell_time_ns;
        logic [CYL_BITS-1:0]     cylinder_number;
        logic [CYL_BITS-1:0]     precomp_start_cylinder;
        logic [SHIFT_BITS-1:0]   precomp_shift_ns;
    } bfp_cfg_t;

    typedef struct packed {
        logic cell_bit;
        logic index_mark;
        logic track_end;
    } bfp_item_t;

endpackage

/* hdl/bfp_cfg.sv */
module bfp_cfg
    import bfp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output bfp_cfg_t                  cfg
);

    bfp_cfg_t cfg_reg;
    bfp_cfg_t cfg_next;

    // Writes are always taken; an index beyond the register list is ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BITCELL_TIME:  cfg_next.bitcell_time_ns        = cfg_data[BITCELL_BITS-1:0];
                REG_CYLINDER:      cfg_next.cylinder_number        = cfg_data[CYL_BITS-1:0];
                REG_PRECOMP_START: cfg_next.precomp_start_cylinder = cfg_data[CYL_BITS-1:0];
                REG_PRECOMP_SHIFT: cfg_next.precomp_shift_ns       = cfg_data[SHIFT_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bitcell_time_ns        <= BITCELL_TIME_RESET;
            cfg_reg.cylinder_number        <= CYLINDER_RESET;
            cfg_reg.precomp_start_cylinder <= PRECOMP_START_RESET;
            cfg_reg.precomp_shift_ns       <= PRECOMP_SHIFT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/bfp_core.sv */
module bfp_core
    import bfp_pkg::*;
#(
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step_en,
    input  bfp_item_t                item,
    input  bfp_cfg_t                 cfg,
    output logic                     res_valid,
    output logic                     res_interval_valid,
    output logic [INTERVAL_BITS-1:0] res_interval_ns,
    output logic                     res_revolution_end
);

    // Two spare bits: one for the overshoot past the maximum, one for sign.
    localparam int ACC_W = INTERVAL_BITS + 2;

    localparam logic signed [ACC_W-1:0] IMAX = {2'b00, {INTERVAL_BITS{1'b1}}};

    logic                    prev_bit_reg, prev_bit_next;
    logic                    cur_bit_reg, cur_bit_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    pending_reg, pending_next;
    logic                    any_rev_reg, any_rev_next;

    logic signed [ACC_W-1:0] cell_time;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic signed [ACC_W-1:0] shift;
    logic signed [ACC_W-1:0] shifted;
    logic                    precomp_on;
    logic                    rev;

    assign cell_time  = signed'({{(ACC_W-BITCELL_BITS){1'b0}}, cfg.bitcell_time_ns});
    assign acc_sum    = acc_reg + cell_time;
    assign acc_sat    = (acc_sum > IMAX) ? IMAX : acc_sum;
    assign precomp_on = (cfg.cylinder_number >= cfg.precomp_start_cylinder)
                        && (prev_bit_reg != item.cell_bit);

    always_comb
    begin
        if (!precomp_on)
            shift = '0;
        else if (prev_bit_reg)
            shift = signed'({{(ACC_W-SHIFT_BITS){1'b0}}, cfg.precomp_shift_ns});
        else
            shift = -signed'({{(ACC_W-SHIFT_BITS){1'b0}}, cfg.precomp_shift_ns});
    end

    assign shifted = acc_sat + shift;

    always_comb
    begin
        res_interval_valid = 1'b0;
        res_interval_ns    = '0;
        acc_next           = acc_sat;
        pending_next       = pending_reg;
        any_rev_next       = any_rev_reg;
        rev                = 1'b0;

        // The held 1 becomes a transition now that the following bit is known.
        if (cur_bit_reg)
        begin
            res_interval_valid = 1'b1;
            if (shifted < 0)
                res_interval_ns = '0;
            else if (shifted > IMAX)
                res_interval_ns = {INTERVAL_BITS{1'b1}};
            else
                res_interval_ns = shifted[INTERVAL_BITS-1:0];
            acc_next     = -shift;
            pending_next = 1'b1;
        end

        prev_bit_next = cur_bit_reg;
        cur_bit_next  = item.cell_bit;

        if (item.index_mark)
        begin
            rev          = 1'b1;
            pending_next = 1'b0;
            any_rev_next = 1'b1;
        end

        // Track end flushes a marker if one is owed and restarts from reset.
        if (item.track_end)
        begin
            if (!any_rev_next || pending_next)
                rev = 1'b1;
            prev_bit_next = 1'b0;
            cur_bit_next  = 1'b0;
            acc_next      = '0;
            pending_next  = 1'b0;
            any_rev_next  = 1'b0;
        end
    end

    assign res_revolution_end = rev;
    assign res_valid          = res_interval_valid | rev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bit_reg <= 1'b0;
            cur_bit_reg  <= 1'b0;
            acc_reg      <= '0;
            pending_reg  <= 1'b0;
            any_rev_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            prev_bit_reg <= prev_bit_next;
            cur_bit_reg  <= cur_bit_next;
            acc_reg      <= acc_next;
            pending_reg  <= pending_next;
            any_rev_reg  <= any_rev_next;
        end
    end

endmodule

/* hdl/bitcell_to_flux_precomp.sv */
// An accepted request is held in the input register; its result, if it yields one, is then
// registered in the result register and offered to the output from there.
// Throughput: one bitcell request per cycle while no stall holds it, set by the accumulator loop.
// An input register and a result register part the two sides, so output stall does not
// stop the input until both hold a request.
// Reset (rst_n, asynchronous, active low) clears all track state and loads the register defaults.
module bitcell_to_flux_precomp
    import bfp_pkg::*;
#(
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      cell_bit,
    input  logic                      index_mark,
    input  logic                      track_end,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      interval_valid,
    output logic [INTERVAL_BITS-1:0]  interval_ns,
    output logic                      revolution_end,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    bfp_cfg_t  cfg;

    // Input register: holds one accepted bitcell request.
    logic      s1_valid_reg, s1_valid_next;
    bfp_item_t s1_item_reg;

    // Result register.
    logic                     out_valid_reg, out_valid_next;
    logic                     out_interval_valid_reg;
    logic [INTERVAL_BITS-1:0] out_interval_ns_reg;
    logic                     out_revolution_end_reg;

    logic                     in_accept;
    logic                     s1_adv;
    logic                     res_valid;
    logic                     res_interval_valid;
    logic [INTERVAL_BITS-1:0] res_interval_ns;
    logic                     res_revolution_end;

    bfp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bfp_core #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_core
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .step_en            (s1_adv),
        .item               (s1_item_reg),
        .cfg                (cfg),
        .res_valid          (res_valid),
        .res_interval_valid (res_interval_valid),
        .res_interval_ns    (res_interval_ns),
        .res_revolution_end (res_revolution_end)
    );

    // The held request moves on unless it has a result and the result register
    // is full and stalled. A request that yields no result only updates the
    // track state, so it never waits for the output side.
    assign s1_adv    = s1_valid_reg && (!res_valid || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        if (s1_adv && res_valid)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.cell_bit   <= cell_bit;
            s1_item_reg.index_mark <= index_mark;
            s1_item_reg.track_end  <= track_end;
        end
        if (s1_adv && res_valid)
        begin
            out_interval_valid_reg <= res_interval_valid;
            out_interval_ns_reg    <= res_interval_ns;
            out_revolution_end_reg <= res_revolution_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign interval_valid = out_interval_valid_reg;
    assign interval_ns    = out_interval_ns_reg;
    assign revolution_end = out_revolution_end_reg;

    // A result always carries an interval or a revolution marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (interval_valid || revolution_end))
        else $error("result with neither interval nor marker");

    // A result without an interval carries a zero interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !interval_valid) |-> (interval_ns == '0))
        else $error("non-zero interval in marker-only result");

    // The input side only stalls while the input register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    // A stalled result stays in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result lost");

endmodule

/* tb/sv/bitcell_to_flux_precomp_tb.sv */
`timescale 1ns / 1ps

module bitcell_to_flux_precomp_tb;
    import bfp_pkg::*;

    localparam int INTERVAL_BITS = INTERVAL_BITS_DEFAULT;
    // The running time needs headroom above the interval width for the sum
    // before saturation and for the negative carry after a late shift.
    localparam int ELAPSED_BITS = INTERVAL_BITS + 3;
    // Cycles allowed after the last expected result before the registers are
    // touched again, long enough for a request to pass the input and result registers.
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT = 7;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RUN_LIMIT_NS = 2000000;

    typedef struct packed {
        logic                     interval_valid;
        logic [INTERVAL_BITS-1:0] interval_ns;
        logic                     revolution_end;
    } flux_result_t;

    // Keeps its own copy of the registers and the track state, turns every
    // accepted bitcell request into the result it should cause, and compares
    // the results that the block hands out against them in order.
    class flux_interval_tracker;
        logic [BITCELL_BITS-1:0]        cell_time;
        logic [CYL_BITS-1:0]            cylinder;
        logic [CYL_BITS-1:0]            precomp_start;
        logic [SHIFT_BITS-1:0]          shift_ns;
        logic                           older_cell;
        logic                           newer_cell;
        logic                           flux_since_marker;
        logic                           marker_seen;
        logic signed [ELAPSED_BITS-1:0] elapsed_ns;
        flux_result_t                   expected_flux[$];
        int                             errors;

        function new();
            cell_time = BITCELL_TIME_RESET;
            cylinder = CYLINDER_RESET;
            precomp_start = PRECOMP_START_RESET;
            shift_ns = PRECOMP_SHIFT_RESET;
            errors = 0;
            clear_track();
        endfunction

        function void clear_track();
            older_cell = 1'b0;
            newer_cell = 1'b0;
            flux_since_marker = 1'b0;
            marker_seen = 1'b0;
            elapsed_ns = '0;
        endfunction

        function void write_register(logic [CFG_INDEX_BITS-1:0] index,
                                     logic [CFG_DATA_BITS-1:0] value);
            case (index)
                REG_BITCELL_TIME:  cell_time = value[BITCELL_BITS-1:0];
                REG_CYLINDER:      cylinder = value[CYL_BITS-1:0];
                REG_PRECOMP_START: precomp_start = value[CYL_BITS-1:0];
                REG_PRECOMP_SHIFT: shift_ns = value[SHIFT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_flux.size();
        endfunction

        function void absorb_bitcell(logic cell_value, logic index_pulse, logic last_cell);
            logic signed [ELAPSED_BITS-1:0] ceiling;
            logic signed [ELAPSED_BITS-1:0] magnitude;
            logic signed [ELAPSED_BITS-1:0] shift;
            logic signed [ELAPSED_BITS-1:0] interval;
            flux_result_t                   flux;

            ceiling = (ELAPSED_BITS'(1) <<< INTERVAL_BITS) - 1;
            magnitude = $signed({{(ELAPSED_BITS-SHIFT_BITS){1'b0}}, shift_ns});
            flux = '0;

            elapsed_ns = elapsed_ns + $signed({{(ELAPSED_BITS-BITCELL_BITS){1'b0}}, cell_time});
            if (elapsed_ns > ceiling)
                elapsed_ns = ceiling;

            // The transition held in the newer cell is placed now that the
            // following cell is known.
            if (newer_cell)
            begin
                shift = '0;
                if (cylinder >= precomp_start && older_cell != cell_value)
                    shift = older_cell ? magnitude : -magnitude;
                interval = elapsed_ns + shift;
                if (interval < 0)
                    interval = '0;
                if (interval > ceiling)
                    interval = ceiling;
                flux.interval_valid = 1'b1;
                flux.interval_ns = interval[INTERVAL_BITS-1:0];
                elapsed_ns = -shift;
                flux_since_marker = 1'b1;
            end

            older_cell = newer_cell;
            newer_cell = cell_value;

            if (index_pulse)
            begin
                flux.revolution_end = 1'b1;
                flux_since_marker = 1'b0;
                marker_seen = 1'b1;
            end

            if (last_cell)
            begin
                if (!marker_seen || flux_since_marker)
                    flux.revolution_end = 1'b1;
                clear_track();
            end

            if (flux.interval_valid || flux.revolution_end)
                expected_flux = {expected_flux, flux};
        endfunction

        function void check_flux_result(logic got_valid, logic [INTERVAL_BITS-1:0] got_ns,
                                        logic got_end);
            flux_result_t want;

            if (expected_flux.size() == 0)
            begin
                $display("%0t: unexpected result interval_valid=%0b interval_ns=%0d %s=%0b",
                         $time, got_valid, got_ns, "revolution_end", got_end);
                errors++;
                return;
            end
            want = expected_flux.pop_front();
            if (got_valid !== want.interval_valid)
            begin
                $display("%0t: interval_valid expected %0b, got %0b",
                         $time, want.interval_valid, got_valid);
                errors++;
            end
            if (got_ns !== want.interval_ns)
            begin
                $display("%0t: interval_ns expected %0d, got %0d", $time, want.interval_ns, got_ns);
                errors++;
            end
            if (got_end !== want.revolution_end)
            begin
                $display("%0t: revolution_end expected %0b, got %0b",
                         $time, want.revolution_end, got_end);
                errors++;
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      cell_bit = 1'b0;
    logic                      index_mark = 1'b0;
    logic                      track_end = 1'b0;

    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      interval_valid;
    logic [INTERVAL_BITS-1:0]  interval_ns;
    logic                      revolution_end;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    flux_interval_tracker      tracker;

    // While calm is set neither side idles; this gives one long stretch at
    // full rate. hold_off_go asks the receiving side for one long hold-off.
    bit                        calm = 1'b0;
    bit                        hold_off_go = 1'b0;
    bit                        hold_off_done = 1'b0;
    int                        hold_left = 0;

    bitcell_to_flux_precomp #(
        .INTERVAL_BITS(INTERVAL_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cell_bit(cell_bit),
        .index_mark(index_mark),
        .track_end(track_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .interval_valid(interval_valid),
        .interval_ns(interval_ns),
        .revolution_end(revolution_end),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Receiving side. Values read just after the edge are those that the
    // edge itself saw, because every driver updates in the nonblocking region.
    // The stall for the next cycle is decided here as well, once per edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_flux_result(interval_valid, interval_ns, revolution_end);

        if (hold_off_go && !hold_off_done)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
        end

        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Offers one bitcell request, sometimes after a short idle gap, and
    // returns at the edge that accepts it. The request is then noted for
    // prediction. The task is always entered just after an edge.
    task automatic send_request(input logic cell_value, input logic index_pulse,
                                input logic last_cell);
        int gap;

        gap = 0;
        if (!calm && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end

        in_valid <= 1'b1;
        cell_bit <= cell_value;
        index_mark <= index_pulse;
        track_end <= last_cell;
        do
            @(posedge clk);
        while (in_stall);

        tracker.absorb_bitcell(cell_value, index_pulse, last_cell);
    endtask

    // Stops offering and waits until every predicted result has been taken,
    // then lets the block settle, since a request may cause no result at all.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write. The valid is left high so that back-to-back writes
    // never lower and raise it within a single time step.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);

        tracker.write_register(index, value);
    endtask

    // Writes all four registers, then one index beyond the list, which must
    // leave every register as it is. Bits above a register's width are kept
    // in the data so that the block is seen to ignore them.
    task automatic write_settings(input logic [CFG_DATA_BITS-1:0] cell_time,
                                  input logic [CFG_DATA_BITS-1:0] cylinder,
                                  input logic [CFG_DATA_BITS-1:0] precomp_start,
                                  input logic [CFG_DATA_BITS-1:0] shift_ns);
        write_reg(REG_BITCELL_TIME, cell_time);
        write_reg(REG_CYLINDER, cylinder);
        write_reg(REG_PRECOMP_START, precomp_start);
        write_reg(REG_PRECOMP_SHIFT, shift_ns);
        write_reg(CFG_INDEX_BITS'($urandom_range((1 << CFG_INDEX_BITS) - 1,
                                                 REG_PRECOMP_SHIFT + 1)),
                  CFG_DATA_BITS'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Random bitcell stream in runs of differing density. A sparse stream
    // leaves long gaps between transitions, so the running time saturates.
    // When pause_at is positive the sender stops once at that item until
    // every expected result has come out.
    task automatic random_phase(input int count, input bit sparse, input int pause_at);
        int one_permil;
        int mark_permil;
        int end_permil;
        int run_left;
        int sent;

        one_permil = 500;
        mark_permil = sparse ? 5 : 25;
        end_permil = sparse ? 3 : 15;
        run_left = 0;
        sent = 0;
        repeat (count)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(60, 15);
                case ($urandom_range(3))
                    0: one_permil = 500;
                    1: one_permil = 300;
                    2: one_permil = 750;
                    default: one_permil = 100;
                endcase
                if (sparse)
                    one_permil = 15;
            end
            run_left--;

            if (pause_at > 0 && sent == pause_at)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (tracker.pending() != 0);
            end

            send_request($urandom_range(999) < one_permil,
                         $urandom_range(999) < mark_permil,
                         $urandom_range(999) < end_permil);
            sent++;
        end
    endtask

    initial
    begin
        tracker = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // At the reset settings cylinder 0 lies below the start cylinder, so
        // a transition between a 1 and a 0 takes no shift.
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b0, 1'b0, 1'b0);
        drain();

        // Cylinder equal to the start cylinder: precompensation applies.
        write_settings(16'd2000, 16'd40, 16'd40, 16'd240);
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b0, 1'b0, 1'b0);    // equal neighbours, no shift
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b1, 1'b0, 1'b0);    // bit after is 1: early
        send_request(1'b0, 1'b0, 1'b0);    // bit before is 1: late
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b1, 1'b1, 1'b0);    // interval and index in one result
        send_request(1'b1, 1'b0, 1'b0);    // both neighbours 1, no shift
        send_request(1'b0, 1'b1, 1'b0);    // index while a 1 is held: interval and index
        send_request(1'b0, 1'b0, 1'b1);    // track end after a marker: silent
        send_request(1'b0, 1'b0, 1'b1);    // track end before any marker
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b0, 1'b0, 1'b0);
        send_request(1'b1, 1'b0, 1'b1);    // the 1 at track end is dropped
        send_request(1'b1, 1'b1, 1'b1);    // index and track end together
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b1, 1'b1, 1'b1);    // interval with index and track end
        drain();

        // A bitcell time shorter than the shift drives an early interval
        // below zero, which must clamp to 0. The data carries a stray upper bit.
        write_settings(16'h4010, 16'd255, 16'd0, 16'd255);
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b0, 1'b0, 1'b0);
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b1, 1'b0, 1'b0);
        send_request(1'b0, 1'b0, 1'b0);
        drain();

        // Full rate on both sides for a whole phase.
        calm = 1'b1;
        write_settings(16'd2000, 16'd100, 16'd40, 16'd240);
        random_phase(90, 1'b0, 0);
        drain();
        calm = 1'b0;

        // Shortest legal bitcell, largest shift, cylinder on the boundary.
        // Halfway through, the sender waits for every result to come out.
        write_settings(16'd256, 16'd255, 16'd255, 16'd255);
        random_phase(90, 1'b0, 45);
        drain();

        // Longest bitcell with sparse transitions: the running time and the
        // interval saturate, first without and then with a shift on top.
        write_settings(16'd16383, 16'd0, 16'd0, 16'd0);
        random_phase(150, 1'b1, 0);
        drain();
        write_settings(16'hFFFF, 16'hAAC8, 16'h5500, 16'hFFFF);
        random_phase(150, 1'b1, 0);
        drain();

        // Tiny bitcell against a large shift, while the receiver holds off
        // long enough for the block to fill and stall its input.
        write_settings(16'h4014, 16'd10, 16'd9, 16'd255);
        hold_off_go = 1'b1;
        random_phase(90, 1'b0, 0);
        drain();

        // Cylinder just below the start cylinder: no precompensation.
        write_settings(16'd1000, 16'd39, 16'd40, 16'd128);
        random_phase(90, 1'b0, 0);
        drain();

        repeat (3)
        begin
            write_settings(CFG_DATA_BITS'($urandom_range(16383, 256))
                               | CFG_DATA_BITS'($urandom_range(3) << BITCELL_BITS),
                           CFG_DATA_BITS'($urandom),
                           CFG_DATA_BITS'($urandom),
                           CFG_DATA_BITS'($urandom));
            random_phase(90, 1'b0, 0);
            drain();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("bitcell_to_flux_precomp_tb OK");
        else
            $display("bitcell_to_flux_precomp_tb NOT OK");
        $finish;
    end

    // Guard against a block that stops answering.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("bitcell_to_flux_precomp_tb NOT OK");
        $finish;
    end

endmodule

/* files.f */
hdl/bfp_pkg.sv
hdl/bfp_cfg.sv
hdl/bfp_core.sv
hdl/bitcell_to_flux_precomp.sv
tb/sv/bitcell_to_flux_precomp_tb.sv
